// ===== rtl/gyro_bias_statistics_assert.svh =====
// assertion macros for the gyro bias statistics checker
`ifndef GYRO_BIAS_STATISTICS_ASSERT_SVH
`define GYRO_BIAS_STATISTICS_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define GBS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gyro bias statistics check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define GBS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gyro bias statistics check failed");

`endif

// ===== rtl/gbs_pkg.sv =====
// types, constants and widths for the gyro bias statistics block
package gbs_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int MAX_SAMPLES = 1048576;

	localparam int NUM_AXES = 3;
	localparam int AXIS_W   = 2;
	localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W    = SAMPLE_BITS + CNT_W;
	localparam int SQR_W    = 2 * SAMPLE_BITS;
	localparam int SQ_W     = 2 * SAMPLE_BITS + CNT_W - 2;
	localparam int DIV_W    = SQ_W + FRAC_BITS;
	localparam int DCNT_W   = $clog2(DIV_W + 1);
	localparam int MEAN_W   = SAMPLE_BITS + FRAC_BITS;
	localparam int VAR_W    = 2 * SAMPLE_BITS - 1 + FRAC_BITS;
	localparam int MSQ_W    = 2 * MEAN_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic OP_MODE   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	typedef enum logic {
		KIND_ACCUM,
		KIND_REPORT
	} kind_t;

	typedef struct packed {
		kind_t                                   kind;
		logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]    smp;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ACCUM,
		BK_DIV_START,
		BK_DIV_WAIT,
		BK_SQUARE,
		BK_EMIT
	} back_state_t;

endpackage

// ===== rtl/gbs_front.sv =====
// front end: takes requests, keeps the mode flag and session state, queues work
module gbs_front import gbs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  logic                   mode_value,
	input  logic [SAMPLE_BITS-1:0] gyro_x,
	input  logic [SAMPLE_BITS-1:0] gyro_y,
	input  logic [SAMPLE_BITS-1:0] gyro_z,
	input  queue_status_t          q_status,
	output logic                   push,
	output entry_t                 push_entry
);

	logic mode_flag_q;
	logic active_q;
	logic accept;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !q_status.full;

	// a tick only matters inside a session; flag clear means it closes the session
	assign push            = accept && (operation == OP_SAMPLE) && active_q;
	assign push_entry.kind = mode_flag_q ? KIND_ACCUM : KIND_REPORT;
	assign push_entry.smp  = {gyro_z, gyro_y, gyro_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_flag_q <= 1'b0;
			active_q    <= 1'b0;
		end else if (accept) begin
			if (operation == OP_MODE) begin
				mode_flag_q <= mode_value;
				if (mode_value) begin
					active_q <= 1'b1;
				end
			end else if (active_q && !mode_flag_q) begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/gbs_queue.sv =====
// two-entry work queue between front and back
module gbs_queue import gbs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  entry_t        push_entry,
	input  logic          pop,
	output queue_status_t status,
	output entry_t        head
);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/gbs_div.sv =====
// restoring divider, one quotient bit per cycle
module gbs_div import gbs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DCNT_W-1:0] steps_q;
	logic [DIV_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              ge;

	assign trial    = {rem_q, quo_q[DIV_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign ge       = (trial >= {1'b0, dvs_q});
	assign done     = (steps_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (start) begin
			steps_q <= DCNT_W'(DIV_W);
		end else if (!done) begin
			steps_q <= steps_q - 1'b1;
		end
	end

	// dividend shifts out the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (!done) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

endmodule

// ===== rtl/gbs_back.sv =====
// back end: accumulates samples and produces the per-axis reports
module gbs_back import gbs_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  queue_status_t                 q_status,
	input  entry_t                        q_head,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [AXIS_W-1:0]             axis,
	output logic [CNT_W-1:0]              sample_count,
	output logic signed [MEAN_W-1:0]      mean,
	output logic signed [SAMPLE_BITS-1:0] minimum,
	output logic signed [SAMPLE_BITS-1:0] maximum,
	output logic [VAR_W-1:0]              variance,
	output logic                          last
);

	back_state_t state_q, state_d;

	logic signed [SAMPLE_BITS-1:0] smp_q   [NUM_AXES];
	logic [SQR_W-1:0]              sqr_q   [NUM_AXES];
	logic signed [SUM_W-1:0]       sum_q   [NUM_AXES];
	logic [SQ_W-1:0]               sqsum_q [NUM_AXES];
	logic signed [SAMPLE_BITS-1:0] min_q   [NUM_AXES];
	logic signed [SAMPLE_BITS-1:0] max_q   [NUM_AXES];
	logic signed [SQR_W-1:0]       prod    [NUM_AXES];
	logic [CNT_W-1:0]              total_q;
	logic [AXIS_W-1:0]             axis_q;
	logic [MEAN_W-1:0]             q_q;
	logic [VAR_W-1:0]              m2_q;
	logic [MSQ_W-1:0]              msq_q;
	logic [MSQ_W-1:0]              qq;

	logic capture, rep_begin, accum_en, div_start, div_take, msq_en, out_load;
	logic last_axis;

	logic             neg;
	logic [SUM_W-1:0] mag;
	logic [DIV_W-1:0] mean_dividend, m2_dividend;
	logic [DIV_W-1:0] mean_quo, m2_quo;
	logic             mean_done, m2_done;
	logic [MEAN_W-1:0] mean_d;
	logic [VAR_W-1:0]  var_d;

	assign last_axis = (axis_q == AXIS_Z);

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			prod[a] = $signed(q_head.smp[a]) * $signed(q_head.smp[a]);
		end
	end

	assign neg           = sum_q[axis_q][SUM_W-1];
	assign mag           = neg ? -sum_q[axis_q] : sum_q[axis_q];
	assign mean_dividend = DIV_W'(mag) << FRAC_BITS;
	assign m2_dividend   = DIV_W'(sqsum_q[axis_q]) << FRAC_BITS;

	gbs_div u_div_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mean_dividend),
		.divisor  (total_q),
		.done     (mean_done),
		.quotient (mean_quo)
	);

	gbs_div u_div_m2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (m2_dividend),
		.divisor  (total_q),
		.done     (m2_done),
		.quotient (m2_quo)
	);

	assign qq = q_q * q_q;

	// empty session reports zero mean and variance
	always_comb begin
		mean_d = '0;
		var_d  = '0;
		if (total_q != '0) begin
			mean_d = neg ? -q_q : q_q;
			if (MSQ_W'(m2_q) > msq_q) begin
				var_d = VAR_W'(MSQ_W'(m2_q) - msq_q);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					state_d = (q_head.kind == KIND_ACCUM) ? BK_ACCUM : BK_DIV_START;
				end
			end
			BK_ACCUM:     state_d = BK_IDLE;
			BK_DIV_START: state_d = BK_DIV_WAIT;
			BK_DIV_WAIT: begin
				if (mean_done && m2_done) begin
					state_d = BK_SQUARE;
				end
			end
			BK_SQUARE:    state_d = BK_EMIT;
			BK_EMIT: begin
				if (!out_valid || !out_stall) begin
					state_d = last_axis ? BK_IDLE : BK_DIV_START;
				end
			end
			default:      state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		capture   = 1'b0;
		rep_begin = 1'b0;
		accum_en  = 1'b0;
		div_start = 1'b0;
		div_take  = 1'b0;
		msq_en    = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_pop     = !q_status.empty;
				capture   = !q_status.empty && (q_head.kind == KIND_ACCUM);
				rep_begin = !q_status.empty && (q_head.kind == KIND_REPORT);
			end
			BK_ACCUM:     accum_en  = (total_q != CNT_W'(MAX_SAMPLES));
			BK_DIV_START: div_start = 1'b1;
			BK_DIV_WAIT:  div_take  = mean_done && m2_done;
			BK_SQUARE:    msq_en    = 1'b1;
			BK_EMIT:      out_load  = !out_valid || !out_stall;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			out_valid <= 1'b0;
			axis_q    <= AXIS_X;
			total_q   <= '0;
			for (int a = 0; a < NUM_AXES; a++) begin
				sum_q[a]   <= '0;
				sqsum_q[a] <= '0;
				min_q[a]   <= SMP_MAX;
				max_q[a]   <= SMP_MIN;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (rep_begin) begin
				axis_q <= AXIS_X;
			end else if (out_load && !last_axis) begin
				axis_q <= axis_q + 1'b1;
			end
			if (accum_en) begin
				total_q <= total_q + 1'b1;
				for (int a = 0; a < NUM_AXES; a++) begin
					sum_q[a]   <= sum_q[a] + SUM_W'(smp_q[a]);
					sqsum_q[a] <= sqsum_q[a] + SQ_W'(sqr_q[a]);
					if (smp_q[a] < min_q[a]) begin
						min_q[a] <= smp_q[a];
					end
					if (smp_q[a] > max_q[a]) begin
						max_q[a] <= smp_q[a];
					end
				end
			end else if (out_load && last_axis) begin
				total_q <= '0;
				for (int a = 0; a < NUM_AXES; a++) begin
					sum_q[a]   <= '0;
					sqsum_q[a] <= '0;
					min_q[a]   <= SMP_MAX;
					max_q[a]   <= SMP_MIN;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				smp_q[a] <= $signed(q_head.smp[a]);
				sqr_q[a] <= $unsigned(prod[a]);
			end
		end
		if (div_take) begin
			q_q  <= mean_quo[MEAN_W-1:0];
			m2_q <= m2_quo[VAR_W-1:0];
		end
		if (msq_en) begin
			msq_q <= qq >> FRAC_BITS;
		end
		if (out_load) begin
			axis         <= axis_q;
			sample_count <= total_q;
			mean         <= $signed(mean_d);
			minimum      <= min_q[axis_q];
			maximum      <= max_q[axis_q];
			variance     <= var_d;
			last         <= last_axis;
		end
	end

endmodule

// ===== rtl/gyro_bias_statistics.sv =====
// sample tick: queued, then captured with its squares and accumulated by the back end
// the back end takes the next sample only after it has accumulated the last one
// stop tick: the axes are reported in turn, X, Y then Z, each with mean and variance from
// the two restoring dividers that make one quotient bit per cycle
// mode requests are taken by the front end, not queued, and produce no report
// arst_n clears session state, statistics, queue and output valid
module gyro_bias_statistics import gbs_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic                          mode_value,
	input  logic signed [SAMPLE_BITS-1:0] gyro_x,
	input  logic signed [SAMPLE_BITS-1:0] gyro_y,
	input  logic signed [SAMPLE_BITS-1:0] gyro_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [AXIS_W-1:0]             axis,
	output logic [CNT_W-1:0]              sample_count,
	output logic signed [MEAN_W-1:0]      mean,
	output logic signed [SAMPLE_BITS-1:0] minimum,
	output logic signed [SAMPLE_BITS-1:0] maximum,
	output logic [VAR_W-1:0]              variance,
	output logic                          last
);

	queue_status_t q_status;
	logic          push;
	logic          pop;
	entry_t        push_entry;
	entry_t        head;

	gbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.mode_value (mode_value),
		.gyro_x     (gyro_x),
		.gyro_y     (gyro_y),
		.gyro_z     (gyro_z),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	gbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.status     (q_status),
		.head       (head)
	);

	gbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.q_head       (head),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.axis         (axis),
		.sample_count (sample_count),
		.mean         (mean),
		.minimum      (minimum),
		.maximum      (maximum),
		.variance     (variance),
		.last         (last)
	);

endmodule

// ===== rtl/gbs_checker.sv =====
// port-level checks for the gyro bias statistics block, bound to the top level
`include "gyro_bias_statistics_assert.svh"

module gbs_checker import gbs_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [AXIS_W-1:0]             axis,
	input logic [CNT_W-1:0]              sample_count,
	input logic signed [MEAN_W-1:0]      mean,
	input logic signed [SAMPLE_BITS-1:0] minimum,
	input logic signed [SAMPLE_BITS-1:0] maximum,
	input logic [VAR_W-1:0]              variance,
	input logic                          last
);

	`GBS_ASSERT_IMP(a_last_on_z, out_valid, last == (axis == AXIS_Z))
	`GBS_ASSERT_IMP(a_axis_known, out_valid, axis == AXIS_X || axis == AXIS_Y || axis == AXIS_Z)
	`GBS_ASSERT_IMP(a_empty_zero, out_valid && sample_count == 0, mean == 0 && variance == 0)
	`GBS_ASSERT_IMP(a_min_le_max, out_valid && sample_count != 0, minimum <= maximum)
	`GBS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(axis) && $stable(variance))

endmodule

bind gyro_bias_statistics gbs_checker u_gbs_checker (.*);
